FILE: rtl/core/rtq_pkg.sv
`timescale 1ns / 1ps

package rtq_pkg;

  // Fixed-point format of the rotation entries and of the quaternion.
  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;

  // Field widths of the two channels.
  localparam int IN_W = 16;
  localparam int QW_W = 15;
  localparam int Q_W  = 16;

  // Diagonal sum: ONE plus or minus three sign-extended entries.
  localparam int SUM_W = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 3;
  localparam int POS_W = SUM_W - 1;
  localparam int SHIFT = FRAC_BITS - 2;
  localparam int RAW_W = POS_W + SHIFT;

  // Square root: STEPS result bits per pipeline stage.
  localparam int STEPS   = 3;
  localparam int NSTAGES = (RAW_W + 2 * STEPS - 1) / (2 * STEPS);
  localparam int ROOT_W  = NSTAGES * STEPS;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;

  // Saturated magnitude and the width used to negate it.
  localparam int MAG_W = (ROOT_W > FRAC_BITS + 1) ? ROOT_W : FRAC_BITS + 1;
  localparam int EXT_W = (MAG_W > Q_W) ? MAG_W : Q_W;

  // Lanes of the datapath, one per quaternion component.
  localparam int NLANE = 4;
  localparam int LN_W  = 0;
  localparam int LN_X  = 1;
  localparam int LN_Y  = 2;
  localparam int LN_Z  = 3;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_lane_t;

  typedef struct packed {
    root_lane_t [NLANE-1:0] lane;
    logic                   neg_x;
    logic                   neg_y;
    logic                   neg_z;
  } root_beat_t;

endpackage

FILE: rtl/core/rtq_in_if.sv
`timescale 1ns / 1ps

interface rtq_in_if;
  import rtq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] r00;
  logic signed [IN_W-1:0] r01;
  logic signed [IN_W-1:0] r02;
  logic signed [IN_W-1:0] r10;
  logic signed [IN_W-1:0] r11;
  logic signed [IN_W-1:0] r12;
  logic signed [IN_W-1:0] r20;
  logic signed [IN_W-1:0] r21;
  logic signed [IN_W-1:0] r22;

  modport source (
    output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
    input  ready
  );

  modport sink (
    input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
    output ready
  );
endinterface

FILE: rtl/core/rtq_out_if.sv
`timescale 1ns / 1ps

interface rtq_out_if;
  import rtq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [QW_W-1:0]       qw;
  logic signed [Q_W-1:0] qx;
  logic signed [Q_W-1:0] qy;
  logic signed [Q_W-1:0] qz;

  modport source (
    output valid, qw, qx, qy, qz,
    input  ready
  );

  modport sink (
    input  valid, qw, qx, qy, qz,
    output ready
  );
endinterface

FILE: rtl/core/rtq_diag.sv
`timescale 1ns / 1ps

module rtq_diag (
  input  logic                clk,
  input  logic                rst,
  rtq_in_if.sink              rot,
  output logic                out_valid,
  input  logic                out_ready,
  output rtq_pkg::root_beat_t out_beat
);
  import rtq_pkg::*;

  localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(ONE);

  logic signed [SUM_W-1:0] e00;
  logic signed [SUM_W-1:0] e11;
  logic signed [SUM_W-1:0] e22;
  logic signed [SUM_W-1:0] sum [NLANE];
  logic [POS_W-1:0]        pos [NLANE];
  root_beat_t              beat_next;

  assign rot.ready = !out_valid || out_ready;

  always_comb begin
    e00 = SUM_W'(rot.r00);
    e11 = SUM_W'(rot.r11);
    e22 = SUM_W'(rot.r22);
    sum[LN_W] = ONE_S + e00 + e11 + e22;
    sum[LN_X] = ONE_S + e00 - e11 - e22;
    sum[LN_Y] = ONE_S - e00 + e11 - e22;
    sum[LN_Z] = ONE_S - e00 - e11 + e22;
    for (int l = 0; l < NLANE; l++) begin
      // A negative or zero sum has a zero root.
      pos[l] = (sum[l] > 0) ? sum[l][POS_W-1:0] : '0;
      beat_next.lane[l].rad  = {{(RAD_W - POS_W){1'b0}}, pos[l]} << SHIFT;
      beat_next.lane[l].rem  = '0;
      beat_next.lane[l].root = '0;
    end
    beat_next.neg_x = rot.r21 < rot.r12;
    beat_next.neg_y = rot.r02 < rot.r20;
    beat_next.neg_z = rot.r10 < rot.r01;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rot.ready) begin
      out_valid <= rot.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rot.ready && rot.valid) begin
      out_beat <= beat_next;
    end
  end
endmodule

FILE: rtl/core/rtq_root_stage.sv
`timescale 1ns / 1ps

module rtq_root_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rtq_pkg::root_beat_t in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output rtq_pkg::root_beat_t out_beat
);
  import rtq_pkg::*;

  root_beat_t beat_next;

  // One restoring square-root step: bring down two radicand bits and try
  // to subtract 4*root+1 from the partial remainder.
  function automatic root_lane_t root_step(input root_lane_t a);
    root_lane_t       b;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    rem_sh = {a.rem[REM_W-3:0], a.rad[RAD_W-1 -: 2]};
    trial  = {a.root, 2'b01};
    b.rad  = {a.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      b.rem  = rem_sh - trial;
      b.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem  = rem_sh;
      b.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return b;
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    beat_next = in_beat;
    for (int l = 0; l < NLANE; l++) begin
      for (int s = 0; s < STEPS; s++) begin
        beat_next.lane[l] = root_step(beat_next.lane[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_beat <= beat_next;
    end
  end
endmodule

FILE: rtl/core/rtq_sign.sv
`timescale 1ns / 1ps

module rtq_sign (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rtq_pkg::root_beat_t in_beat,
  rtq_out_if.source           quat
);
  import rtq_pkg::*;

  localparam logic [MAG_W-1:0] ONE_M = MAG_W'(ONE);

  logic [MAG_W-1:0] mag [NLANE];
  logic [EXT_W-1:0] ext [NLANE];
  logic [EXT_W-1:0] sx;
  logic [EXT_W-1:0] sy;
  logic [EXT_W-1:0] sz;

  assign in_ready = !quat.valid || quat.ready;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      // Out-of-range entries can push a root above one; clip it there.
      mag[l] = MAG_W'(in_beat.lane[l].root);
      if (mag[l] > ONE_M) begin
        mag[l] = ONE_M;
      end
      ext[l] = EXT_W'(mag[l]);
    end
    sx = in_beat.neg_x ? (EXT_W'(0) - ext[LN_X]) : ext[LN_X];
    sy = in_beat.neg_y ? (EXT_W'(0) - ext[LN_Y]) : ext[LN_Y];
    sz = in_beat.neg_z ? (EXT_W'(0) - ext[LN_Z]) : ext[LN_Z];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.valid <= 1'b0;
    end else if (in_ready) begin
      quat.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      quat.qw <= ext[LN_W][QW_W-1:0];
      quat.qx <= sx[Q_W-1:0];
      quat.qy <= sy[Q_W-1:0];
      quat.qz <= sz[Q_W-1:0];
    end
  end
endmodule

FILE: rtl/core/rotation_to_quaternion_unit.sv
// Pipeline: diagonal sums, NSTAGES root stages (five with 14 fraction bits) and sign,
//   each one registered, between an accepted input beat and its output beat.
// Throughput: one beat per cycle while the output accepts; the four square roots run as
//   3-bit-per-stage pipelines, so a new matrix can enter every cycle unless stalled.
// Reset: synchronous, active high; it clears every stage valid bit, payload
//   registers keep their contents.
`timescale 1ns / 1ps

module rotation_to_quaternion_unit (
  input  logic    clk,
  input  logic    rst,
  rtq_in_if.sink  rot,
  rtq_out_if.source quat
);
  import rtq_pkg::*;

  // The datapath is a chain of elastic register stages. Each stage loads a
  // new beat whenever it is empty or its own beat moves on in the same
  // cycle, so bubbles collapse and a stalled output holds everything behind
  // it without dropping or repeating a beat.
  //
  // Stage 0 forms the four diagonal sums 1 +/- r00 +/- r11 +/- r22, clamps
  // them at zero, scales them into square-root radicands and captures the
  // sign of each off-diagonal difference.
  // Stages 1..NSTAGES each produce STEPS bits of all four roots with the
  // restoring digit-by-digit method. The root of sum << (FRAC_BITS - 2) is
  // half the square root of the sum in the same fixed-point format.
  // The final stage clips each magnitude at one, applies the signs to x, y
  // and z and registers the output beat.

  logic       vld [NSTAGES + 1];
  logic       rdy [NSTAGES + 1];
  root_beat_t beat [NSTAGES + 1];

  rtq_diag u_diag (
    .clk       (clk),
    .rst       (rst),
    .rot       (rot),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_beat  (beat[0])
  );

  for (genvar k = 0; k < NSTAGES; k++) begin : g_root
    rtq_root_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_beat   (beat[k]),
      .out_valid (vld[k + 1]),
      .out_ready (rdy[k + 1]),
      .out_beat  (beat[k + 1])
    );
  end

  rtq_sign u_sign (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[NSTAGES]),
    .in_ready (rdy[NSTAGES]),
    .in_beat  (beat[NSTAGES]),
    .quat     (quat)
  );

  // Reset empties the whole pipeline, so no output beat follows it.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !quat.valid)
    else $error("output beat present right after reset");

  // With the output stage empty every stage can load, so input is taken.
  a_ready_when_drained : assert property (@(posedge clk) disable iff (rst)
    !quat.valid |-> rot.ready)
    else $error("input stalled while the output stage is empty");

  // The scalar part is a clipped magnitude and never exceeds one.
  a_qw_bound : assert property (@(posedge clk) disable iff (rst)
    quat.valid |-> ((FRAC_BITS >= QW_W) || (quat.qw <= QW_W'(ONE))))
    else $error("qw above one");
endmodule

FILE: tb/tb_rotation_to_quaternion_unit.sv
`timescale 1ns / 1ps

module tb_rotation_to_quaternion_unit;
  import rtq_pkg::*;

  // One pose matrix (rotation part only) and one quaternion beat, in channel order.
  typedef struct packed {
    logic signed [IN_W-1:0] r00, r01, r02;
    logic signed [IN_W-1:0] r10, r11, r12;
    logic signed [IN_W-1:0] r20, r21, r22;
  } pose_t;

  typedef struct packed {
    logic [QW_W-1:0]       qw;
    logic signed [Q_W-1:0] qx, qy, qz;
  } quat_t;

  // A directed row carries its quaternion only where the answer is obvious by hand;
  // every other row is scored by the predictor below.
  typedef struct packed {
    pose_t pose;
    logic  has_quat;
    quat_t quat;
  } pose_case_t;

  localparam int HALF         = ONE / 2;
  localparam int RANDOM_BEATS = 600;
  localparam int HOLD_AT      = 150;   // random beat at which the output side holds off
  localparam int HOLD_BURST   = 40;    // back-to-back beats offered during that hold
  localparam int HOLD_CYCLES  = 80;
  localparam int PAUSE_AT     = 400;   // random beat before which the input side drains
  localparam int DRAIN_CYCLES = 20;    // settling at the end, after the last quaternion has been checked

  // Directed rows: identity, the zero matrix, the three half turns, saturated and
  // all-negative entries (negative diagonal sums clamp to zero), quarter turns in
  // both directions so every sign takes both values, symmetric off-diagonals
  // (zero differences must give positive components), differences of one LSB and
  // of full scale, and diagonal sums of exactly one LSB and of minus one LSB.
  localparam int N_DIRECTED = 19;
  localparam pose_case_t DIRECTED_CASES [N_DIRECTED] = '{
    '{'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE},        1'b1, '{ONE, 0, 0, 0}},
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0},              1'b1, '{HALF, HALF, HALF, HALF}},
    '{'{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE},      1'b1, '{0, ONE, 0, 0}},
    '{'{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE},      1'b1, '{0, 0, ONE, 0}},
    '{'{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE},      1'b1, '{0, 0, 0, ONE}},
    '{'{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE}, 1'b1, '{ONE, 0, 0, 0}},
    '{'{-ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE}, 1'b0, '0},
    '{'{ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0},       1'b0, '0},
    '{'{ONE, 0, 0, 0, 0, ONE, 0, -ONE, 0},       1'b0, '0},
    '{'{0, 0, ONE, 0, ONE, 0, -ONE, 0, 0},       1'b0, '0},
    '{'{0, 0, -ONE, 0, ONE, 0, ONE, 0, 0},       1'b0, '0},
    '{'{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE},       1'b0, '0},
    '{'{0, ONE, 0, -ONE, 0, 0, 0, 0, ONE},       1'b0, '0},
    '{'{0, HALF, -ONE, HALF, 0, ONE, -ONE, ONE, 0}, 1'b1, '{HALF, HALF, HALF, HALF}},
    '{'{0, 0, 0, -1, 0, 0, 1, -1, 0},            1'b1, '{HALF, -HALF, -HALF, -HALF}},
    '{'{0, ONE, -ONE, -ONE, 0, ONE, ONE, -ONE, 0}, 1'b1, '{HALF, -HALF, -HALF, -HALF}},
    '{'{ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE},       1'b0, '0},
    '{'{-ONE, 0, 0, 0, 0, 0, 0, 0, 1},           1'b0, '0},
    '{'{-ONE, 0, 0, 0, -1, 0, 0, 0, 0},          1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;

  rtq_in_if  rot_bus ();
  rtq_out_if quat_bus ();

  rotation_to_quaternion_unit DUT (
    .clk  (clk),
    .rst  (rst),
    .rot  (rot_bus),
    .quat (quat_bus)
  );

  always #2 clk = ~clk;

  // Quaternions still owed by the block, oldest first.
  quat_t pending_quats [$];

  int  errors        = 0;
  int  beats_in      = 0;
  int  quats_checked = 0;
  int  input_stalls  = 0;
  bit  hold_off_req  = 1'b0;

  // Half of the square root of one diagonal sum, in the Q2.14 format of the
  // entries. A negative or zero sum yields zero. The root is built one bit at a
  // time from the top and saturated at 1.0, which in-range entries never exceed.
  function automatic logic [Q_W-1:0] half_root(input longint diag_sum);
    longint unsigned radicand;
    longint unsigned root;
    longint unsigned trial;
    if (diag_sum <= 0) return '0;
    radicand = longint'(diag_sum) << (FRAC_BITS - 2);
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    if (root > ONE) root = ONE;
    return root[Q_W-1:0];
  endfunction

  // A vector component takes the sign of its off-diagonal difference; a zero
  // difference counts as positive.
  function automatic logic [Q_W-1:0] signed_part(input logic [Q_W-1:0] mag,
                                                 input longint diff);
    return (diff < 0) ? -mag : mag;
  endfunction

  function automatic longint as_long(input logic signed [IN_W-1:0] v);
    return v;
  endfunction

  function automatic quat_t predict_quat(input pose_t p);
    longint          m00, m11, m22;
    logic [Q_W-1:0]  w_mag;
    quat_t           q;
    m00 = as_long(p.r00);
    m11 = as_long(p.r11);
    m22 = as_long(p.r22);
    w_mag = half_root(ONE + m00 + m11 + m22);
    q.qw = w_mag[QW_W-1:0];
    q.qx = signed_part(half_root(ONE + m00 - m11 - m22), as_long(p.r21) - as_long(p.r12));
    q.qy = signed_part(half_root(ONE - m00 + m11 - m22), as_long(p.r02) - as_long(p.r20));
    q.qz = signed_part(half_root(ONE - m00 - m11 + m22), as_long(p.r10) - as_long(p.r01));
    return q;
  endfunction

  // Entries stay inside [-1.0, 1.0] but lean on the corners: exact plus and minus
  // one, zero and tiny values, besides a uniform spread over the whole range.
  function automatic logic signed [IN_W-1:0] random_entry();
    case ($urandom_range(0, 7))
      0: return IN_W'(-ONE);
      1: return IN_W'(ONE);
      2: return '0;
      3: return IN_W'(int'($urandom_range(0, 126)) - 63);
      default: return IN_W'(int'($urandom_range(0, 2 * ONE)) - ONE);
    endcase
  endfunction

  // Random matrices come in four flavors: signed permutations (exact rotations
  // and reflections), symmetric ones where every sign difference is zero,
  // strongly diagonal ones, and fully independent entries.
  function automatic pose_t random_pose();
    logic signed [IN_W-1:0] m [9];
    int perm [3];
    int j;
    int t;
    for (int k = 0; k < 9; k++) m[k] = random_entry();
    case ($urandom_range(0, 9))
      0, 1: begin
        perm = '{0, 1, 2};
        for (int k = 2; k > 0; k--) begin
          j = $urandom_range(0, k);
          t = perm[k];
          perm[k] = perm[j];
          perm[j] = t;
        end
        for (int k = 0; k < 9; k++) m[k] = '0;
        for (int row = 0; row < 3; row++) begin
          m[3 * row + perm[row]] = $urandom_range(0, 1) ? IN_W'(ONE) : IN_W'(-ONE);
        end
      end
      2: begin
        m[5] = m[7];
        m[2] = m[6];
        m[1] = m[3];
      end
      3: begin
        foreach (m[k]) begin
          if (k % 4 != 0) m[k] = IN_W'(int'($urandom_range(0, 126)) - 63);
        end
      end
      default: ;
    endcase
    return {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
  endfunction

  // Idle cycles before a beat: mode 0 is back-to-back, mode 1 short gaps,
  // anything else the full range.
  function automatic int draw_idle(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 3);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  // Offers one matrix after the given gap and records what it must produce once
  // the beat is taken. valid is only lowered when a gap follows, so back-to-back
  // beats keep it high without a second assignment in the same step.
  task automatic offer_pose(input pose_t p, input int gap, input quat_t quat_due);
    if (gap > 0) begin
      rot_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rot_bus.valid <= 1'b1;
    {rot_bus.r00, rot_bus.r01, rot_bus.r02,
     rot_bus.r10, rot_bus.r11, rot_bus.r12,
     rot_bus.r20, rot_bus.r21, rot_bus.r22} <= p;
    @(posedge clk);
    while (rot_bus.ready !== 1'b1) begin
      input_stalls++;
      @(posedge clk);
    end
    pending_quats.push_back(quat_due);
    beats_in++;
  endtask

  task automatic compare_field(input string name, input logic signed [Q_W:0] want,
                               input logic signed [Q_W:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_quat(input quat_t got);
    quat_t want;
    if (pending_quats.size() == 0) begin
      errors++;
      $display("%0t ns: quaternion beat with nothing outstanding: qw=%0d qx=%0d qy=%0d qz=%0d",
               $time, got.qw, $signed(got.qx), $signed(got.qy), $signed(got.qz));
      return;
    end
    want = pending_quats.pop_front();
    compare_field("qw", $signed({1'b0, want.qw}), $signed({1'b0, got.qw}));
    compare_field("qx", $signed(want.qx), $signed(got.qx));
    compare_field("qy", $signed(want.qy), $signed(got.qy));
    compare_field("qz", $signed(want.qz), $signed(got.qz));
    quats_checked++;
  endtask

  // Output side: random back-pressure per beat, switching between no stalls,
  // short stalls and long stalls now and then. When the input side asks for it,
  // one long hold-off is counted here while matrices keep arriving.
  initial begin
    int idle;
    int recv_mode;
    recv_mode = 0;
    quat_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_mode = $urandom_range(0, 3);
      idle = hold_off_req ? HOLD_CYCLES : draw_idle(recv_mode);
      hold_off_req = 1'b0;
      if (idle > 0) begin
        quat_bus.ready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      quat_bus.ready <= 1'b1;
      @(posedge clk);
      while (quat_bus.valid !== 1'b1) @(posedge clk);
      check_quat({quat_bus.qw, quat_bus.qx, quat_bus.qy, quat_bus.qz});
    end
  end

  // Input side: reset, the directed table, then the random matrices.
  initial begin
    pose_t      p;
    pose_case_t row;
    int         gap;
    int         send_mode;
    send_mode = 0;
    rst <= 1'b1;
    rot_bus.valid <= 1'b0;
    {rot_bus.r00, rot_bus.r01, rot_bus.r02,
     rot_bus.r10, rot_bus.r11, rot_bus.r12,
     rot_bus.r20, rot_bus.r21, rot_bus.r22} <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < N_DIRECTED; k++) begin
      row = DIRECTED_CASES[k];
      offer_pose(row.pose, draw_idle(send_mode),
                 row.has_quat ? row.quat : predict_quat(row.pose));
    end

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 50 == 0) send_mode = $urandom_range(0, 3);
      // Long output hold-off while matrices are pushed back to back: the
      // pipeline fills and the input handshake must stall without losing data.
      if (i == HOLD_AT) hold_off_req = 1'b1;
      gap = (i >= HOLD_AT && i < HOLD_AT + HOLD_BURST) ? 0 : draw_idle(send_mode);
      // Let the block run completely dry once, then restart from empty.
      if (i == PAUSE_AT) begin
        rot_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_quats.size() != 0) @(posedge clk);
      end
      p = random_pose();
      offer_pose(p, gap, predict_quat(p));
    end
    rot_bus.valid <= 1'b0;

    while (pending_quats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d directed and %0d random pose matrices, %0d quaternions checked.",
             N_DIRECTED, RANDOM_BEATS, quats_checked);
    $display("Input side saw %0d stalled cycles; %0d field mismatches in total.",
             input_stalls, errors);
    if (errors == 0) begin
      $display("rotation_to_quaternion_unit verification clean");
    end else begin
      $display("rotation_to_quaternion_unit verification failed");
    end
    $finish;
  end

  // A hung handshake ends the run here; a correct run needs a small fraction of this.
  initial begin
    #2_000_000;
    $display("rotation_to_quaternion_unit verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rtq_pkg.sv
rtl/core/rtq_in_if.sv
rtl/core/rtq_out_if.sv
rtl/core/rtq_diag.sv
rtl/core/rtq_root_stage.sv
rtl/core/rtq_sign.sv
rtl/core/rotation_to_quaternion_unit.sv
tb/tb_rotation_to_quaternion_unit.sv
